// ===== rtl/bod_pkg.sv =====
// Shared types, constants and the per-side update function of the overload detector.
package bod_pkg;

  // Sample and register widths
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned THR_BITS    = 24;
  localparam int unsigned CNT_BITS    = 16;
  localparam int unsigned CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_ON_THR  = 2'd0;
  localparam logic [1:0] REG_OFF_THR = 2'd1;
  localparam logic [1:0] REG_ON_CNT  = 2'd2;
  localparam logic [1:0] REG_OFF_CNT = 2'd3;

  // Register reset values
  localparam logic [THR_BITS-1:0] ON_THR_RESET  = THR_BITS'(24'h800000);
  localparam logic [THR_BITS-1:0] OFF_THR_RESET = '0;
  localparam logic [CNT_BITS-1:0] ON_CNT_RESET  = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0] OFF_CNT_RESET = CNT_BITS'(1);

  // Input word
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          compression_mode;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic tension_overload;
    logic compression_overload;
  } out_word_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [THR_BITS-1:0] on_threshold;
    logic [THR_BITS-1:0] off_threshold;
    logic [CNT_BITS-1:0] on_count_needed;
    logic [CNT_BITS-1:0] off_count_needed;
  } cfg_t;

  // Classified sample passed from front to back
  typedef struct packed {
    logic is_tension;
    logic above_on;   // magnitude >= on threshold
    logic below_off;  // magnitude <= off threshold
  } cls_t;

  // State of one side
  typedef struct packed {
    logic                active;
    logic [CNT_BITS-1:0] on_cnt;
    logic [CNT_BITS-1:0] off_cnt;
  } side_t;

  // Debounced hysteresis update of one side for one sample
  function automatic side_t side_update(side_t s, logic cand, logic above_on, logic below_off,
                                        logic [CNT_BITS-1:0] on_need,
                                        logic [CNT_BITS-1:0] off_need);
    side_t               r;
    logic [CNT_BITS-1:0] nxt;
    r   = s;
    nxt = '0;
    if (!cand) begin
      r.on_cnt = '0;
      if (s.active && below_off) begin
        nxt = (s.off_cnt < off_need) ? s.off_cnt + CNT_BITS'(1) : s.off_cnt;
        if (nxt >= off_need) begin
          r.active  = 1'b0;
          r.off_cnt = '0;
        end else begin
          r.off_cnt = nxt;
        end
      end else begin
        r.off_cnt = '0;
      end
    end else begin
      r.off_cnt = '0;
      if (!s.active) begin
        if (above_on) begin
          nxt = (s.on_cnt < on_need) ? s.on_cnt + CNT_BITS'(1) : s.on_cnt;
          if (nxt >= on_need) begin
            r.active = 1'b1;
            r.on_cnt = '0;
          end else begin
            r.on_cnt = nxt;
          end
        end else begin
          r.on_cnt = '0;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/bod_front.sv =====
// Front end: accepts sample words, takes the magnitude and side, compares against thresholds.
module bod_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bod_pkg::cfg_t   cfg_i,
  input  logic            push_i,
  input  bod_pkg::in_word_t in_word_i,
  output logic            full_o,
  output logic            cls_valid_o,
  output bod_pkg::cls_t   cls_o,
  input  logic            cls_full_i
);
  import bod_pkg::*;

  logic                   valid_q, valid_d;
  cls_t                   cls_q, cls_d;
  logic                   accept, fwd;
  logic [SAMPLE_BITS-1:0] raw, mag;
  logic [CMP_BITS-1:0]    mag_ext;
  logic                   neg;

  // Handshake: stage frees up when its word moves into the queue
  assign fwd    = valid_q && !cls_full_i;
  assign full_o = valid_q && cls_full_i;
  assign accept = push_i && !full_o;

  // Magnitude and side of the sample; the most negative value keeps its magnitude
  always_comb begin
    raw = in_word_i.sample;
    neg = raw[SAMPLE_BITS-1];
    mag = neg ? (~raw + SAMPLE_BITS'(1)) : raw;
    if (in_word_i.compression_mode) begin
      neg = |mag;
    end
    mag_ext          = CMP_BITS'(mag);
    cls_d.is_tension = !neg;
    cls_d.above_on   = mag_ext >= CMP_BITS'(cfg_i.on_threshold);
    cls_d.below_off  = mag_ext <= CMP_BITS'(cfg_i.off_threshold);
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fwd) begin
      valid_d = 1'b0;
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

  assign cls_valid_o = valid_q;
  assign cls_o       = cls_q;

endmodule

// ===== rtl/bod_cls_fifo.sv =====
// Two-entry queue of classified words between front and back.
module bod_cls_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  bod_pkg::cls_t wr_word_i,
  output logic          full_o,
  input  logic          rd_i,
  output bod_pkg::cls_t rd_word_o,
  output logic          empty_o
);
  import bod_pkg::*;

  cls_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_word_o = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_word_i;
    end
  end

endmodule

// ===== rtl/bod_back.sv =====
// Back end: per-side debounce state, mutual exclusion, and the result queue.
module bod_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bod_pkg::cfg_t      cfg_i,
  input  logic               cls_empty_i,
  input  bod_pkg::cls_t      cls_i,
  output logic               cls_rd_o,
  input  logic               pop_i,
  output logic               empty_o,
  output bod_pkg::out_word_t out_word_o
);
  import bod_pkg::*;

  side_t      ten_q, ten_d, cmp_q, cmp_d;
  side_t      ten_u, cmp_u;
  out_word_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       take, do_rd;

  // Take a word whenever the result queue has room
  assign take     = !cls_empty_i && (cnt_q != 2'd2);
  assign cls_rd_o = take;
  assign do_rd    = pop_i && !empty_o;
  assign empty_o  = cnt_q == 2'd0;

  // Side updates, then only one side may stay active
  always_comb begin
    ten_u = side_update(ten_q, cls_i.is_tension, cls_i.above_on, cls_i.below_off,
                        cfg_i.on_count_needed, cfg_i.off_count_needed);
    cmp_u = side_update(cmp_q, !cls_i.is_tension, cls_i.above_on, cls_i.below_off,
                        cfg_i.on_count_needed, cfg_i.off_count_needed);
    ten_d = ten_u;
    cmp_d = cmp_u;
    priority if (ten_u.active && cmp_u.active) begin
      if (cls_i.is_tension) begin
        cmp_d = '0;
      end else begin
        ten_d = '0;
      end
    end else if (ten_u.active) begin
      cmp_d = '0;
    end else if (cmp_u.active) begin
      ten_d = '0;
    end
  end

  // Result queue count
  always_comb begin
    cnt_d = cnt_q;
    if (take && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !take) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Side state and queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ten_q    <= '0;
      cmp_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (take) begin
        ten_q    <= ten_d;
        cmp_q    <= cmp_d;
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (take) begin
      mem_q[wr_ptr_q] <= '{tension_overload: ten_d.active, compression_overload: cmp_d.active};
    end
  end

  assign out_word_o = mem_q[rd_ptr_q];

endmodule

// ===== rtl/bipolar_overload_detector.sv =====
// Bipolar overload detector: top level with configuration registers.
// A word accepted into the front stage passes the classification queue and the back end to out_word_o.
// Throughput: one word per cycle; front stage, a two-entry queue and a two-entry
// result queue let input and output stall independently.
// Reset: asynchronous, active low; both sides inactive with counters cleared,
// registers at their reset values, both queues empty.
module bipolar_overload_detector (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Sample words
  input  logic               push,
  output logic               full,
  input  bod_pkg::in_word_t  in_word_i,
  // Result words
  output logic               empty,
  input  logic               pop,
  output bod_pkg::out_word_t out_word_o,
  // Configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bod_pkg::*;

  cfg_t cfg_q;
  logic cfg_wr;
  logic cls_valid, cls_full, cls_empty, cls_rd;
  cls_t cls_front, cls_back;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_threshold     <= ON_THR_RESET;
      cfg_q.off_threshold    <= OFF_THR_RESET;
      cfg_q.on_count_needed  <= ON_CNT_RESET;
      cfg_q.off_count_needed <= OFF_CNT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ON_THR:  cfg_q.on_threshold     <= pwdata[THR_BITS-1:0];
        REG_OFF_THR: cfg_q.off_threshold    <= pwdata[THR_BITS-1:0];
        REG_ON_CNT:  cfg_q.on_count_needed  <= pwdata[CNT_BITS-1:0];
        REG_OFF_CNT: cfg_q.off_count_needed <= pwdata[CNT_BITS-1:0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      REG_ON_THR:  prdata = 32'(cfg_q.on_threshold);
      REG_OFF_THR: prdata = 32'(cfg_q.off_threshold);
      REG_ON_CNT:  prdata = 32'(cfg_q.on_count_needed);
      REG_OFF_CNT: prdata = 32'(cfg_q.off_count_needed);
      default:     prdata = '0;
    endcase
  end

  bod_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .in_word_i  (in_word_i),
    .full_o     (full),
    .cls_valid_o(cls_valid),
    .cls_o      (cls_front),
    .cls_full_i (cls_full)
  );

  bod_cls_fifo u_cls_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (cls_valid),
    .wr_word_i(cls_front),
    .full_o   (cls_full),
    .rd_i     (cls_rd),
    .rd_word_o(cls_back),
    .empty_o  (cls_empty)
  );

  bod_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cls_empty_i(cls_empty),
    .cls_i      (cls_back),
    .cls_rd_o   (cls_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_word_o (out_word_o)
  );

endmodule
